// ----- rtl/tlts_pkg.sv -----
`default_nettype none
package tlts_pkg;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_SET    = 2'd1,
    REQ_YIELD  = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_CHECK,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic flip;
    logic fail;
    logic rd;
    logic move;
    logic choose;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_yield;
    logic keep;
    logic act_empty;
    logic flipped;
    logic head_ok;
  } sts_t;

endpackage
`default_nettype wire

// ----- rtl/tlts_ctrl.sv -----
`default_nettype none
module tlts_ctrl
  import tlts_pkg::*;
(
  input  wire  clk,
  input  wire  rst,
  input  wire  in_valid,
  output logic in_ready,
  output logic out_valid,
  input  wire  out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_EXEC;
      S_EXEC:  state_next = (sts.is_yield && !sts.keep) ? S_READ : S_DONE;
      S_READ: begin
        if (!sts.act_empty) begin
          state_next = S_CHECK;
        end else if (sts.flipped) begin
          state_next = S_DONE;
        end
      end
      S_CHECK: state_next = sts.head_ok ? S_DONE : S_READ;
      S_DONE:  if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_EXEC:  cmd.exec = 1'b1;
      S_READ: begin
        cmd.rd   = !sts.act_empty;
        cmd.flip = sts.act_empty && !sts.flipped;
        cmd.fail = sts.act_empty && sts.flipped;
      end
      S_CHECK: begin
        cmd.choose = sts.head_ok;
        cmd.move   = !sts.head_ok;
      end
      S_DONE:  cmd.load_out = !out_valid || out_ready;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/tlts_dpath.sv -----
`default_nettype none
module tlts_dpath
  import tlts_pkg::*;
#(
  parameter int MAX_TASKS     = 16,
  parameter int PRIORITY_BITS = 8
) (
  input  wire        clk,
  input  wire        rst,
  input  cmd_t       cmd,
  output sts_t       sts,
  input  wire  [1:0] req_type,
  input  wire  [3:0] task_id,
  input  wire        list_select,
  input  wire  [7:0] task_priority,
  input  wire        runnable_flag,
  output logic [3:0] run_task,
  output logic       task_valid,
  output logic       switched,
  output logic       no_runnable
);

  localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int LW = $clog2(MAX_TASKS + 1);
  localparam int PB = PRIORITY_BITS;

  // captured request
  logic [1:0]  req;
  logic [3:0]  id;
  logic        sel;
  logic [PB-1:0] pri;
  logic        flag;

  logic [3:0]  list0 [MAX_TASKS];
  logic [3:0]  list1 [MAX_TASKS];
  logic [LW-1:0] len [2];
  logic [PB-1:0] pri_tab [16];
  logic [15:0] run_bits;
  logic        act;
  logic [PB-1:0] slice;
  logic [3:0]  cur;
  logic        cur_valid;
  logic        sw_flag;
  logic        none_flag;
  logic        flipped;
  logic [3:0]  hd;

  logic [15:0]   pri_wide;
  logic [PB-1:0] slice_dec;
  logic          id_ok;
  logic          hd_ok;
  logic          ins_ok;
  logic          pop;
  logic          push_ok;
  logic [LW-1:0] act_len;
  logic [LW-1:0] oth_len;
  logic [LW-1:0] head_addr;
  logic          we0, we1;
  logic [3:0]    wd;

  assign pri_wide  = {8'd0, task_priority};
  assign slice_dec = (slice == '0) ? '0 : slice - 1'b1;
  assign id_ok     = 32'(id) < 32'(MAX_TASKS);
  assign hd_ok     = 32'(hd) < 32'(MAX_TASKS);
  assign act_len   = len[act];
  assign oth_len   = len[~act];
  assign head_addr = act_len - 1'b1;
  assign ins_ok    = cmd.exec && (req == REQ_INSERT) && id_ok
                     && (32'(len[sel]) < 32'(MAX_TASKS));
  assign pop       = cmd.move || cmd.choose;
  assign push_ok   = pop && (32'(oth_len) < 32'(MAX_TASKS));
  assign wd        = cmd.exec ? id : hd;
  assign we0       = (ins_ok && !sel) || (push_ok && act);
  assign we1       = (ins_ok && sel) || (push_ok && !act);

  assign sts.is_yield  = (req == REQ_YIELD);
  assign sts.keep      = (slice_dec != '0) && cur_valid && run_bits[cur];
  assign sts.act_empty = (act_len == '0);
  assign sts.flipped   = flipped;
  assign sts.head_ok   = hd_ok && run_bits[hd];

  // list storage, each list kept bottom-up so the head is the top entry
  always_ff @(posedge clk) begin
    if (we0) list0[len[0][AW-1:0]] <= wd;
    if (we1) list1[len[1][AW-1:0]] <= wd;
    if (cmd.rd) hd <= act ? list1[head_addr[AW-1:0]] : list0[head_addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req  <= req_type;
      id   <= task_id;
      sel  <= list_select;
      pri  <= pri_wide[PB-1:0];
      flag <= runnable_flag;
    end
    if (ins_ok) pri_tab[id] <= pri;
    if (cmd.load_out) begin
      run_task    <= cur_valid ? cur : 4'd0;
      task_valid  <= cur_valid;
      switched    <= sw_flag;
      no_runnable <= none_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len[0]    <= '0;
      len[1]    <= '0;
      run_bits  <= '0;
      act       <= 1'b0;
      slice     <= PB'(1);
      cur       <= '0;
      cur_valid <= 1'b0;
      sw_flag   <= 1'b0;
      none_flag <= 1'b0;
      flipped   <= 1'b0;
    end else begin
      if (cmd.exec) begin
        sw_flag   <= 1'b0;
        none_flag <= 1'b0;
        flipped   <= 1'b0;
        if (ins_ok) len[sel] <= len[sel] + 1'b1;
        if (req == REQ_SET && id_ok) run_bits[id] <= flag;
        if (req == REQ_YIELD) slice <= slice_dec;
      end
      if (cmd.flip) begin
        act     <= ~act;
        flipped <= 1'b1;
      end
      if (cmd.fail) begin
        cur_valid <= 1'b0;
        none_flag <= 1'b1;
      end
      if (pop) begin
        len[act] <= act_len - 1'b1;
        if (push_ok) len[~act] <= oth_len + 1'b1;
      end
      if (cmd.choose) begin
        cur       <= hd;
        cur_valid <= 1'b1;
        slice     <= pri_tab[hd];
        sw_flag   <= 1'b1;
      end
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    32'(len[0]) <= 32'(MAX_TASKS) && 32'(len[1]) <= 32'(MAX_TASKS))
    else $error("list length beyond capacity");
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    !(sw_flag && none_flag))
    else $error("switch and no-runnable both set");
  a_none_invalid: assert property (@(posedge clk) disable iff (rst)
    none_flag |-> !cur_valid)
    else $error("current task valid after failed search");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> act_len != '0)
    else $error("pop from empty list");

endmodule
`default_nettype wire

// ----- rtl/two_list_time_slice_scheduler.sv -----
`default_nettype none
// two-list time-slice scheduler. each request is an insert (task goes on top of
// the chosen list, its time slice recorded), a runnable-flag write, or a yield.
// every request gives exactly one result. insert, set and a yield that keeps
// the current task go from the execute step straight to the result. a yield
// that must pick a new task walks the active list one entry at a time (list
// memory read, then check and move); when the active list runs empty the
// lists are flipped once, and if it runs empty again there is no runnable
// task. one request is worked at a time; a finished result waits in the
// output register while the next request is taken in, and only the final
// step stalls on a full output.
module two_list_time_slice_scheduler
  import tlts_pkg::*;
#(
  parameter int MAX_TASKS     = 16,
  parameter int PRIORITY_BITS = 8
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire  [1:0] req_type,
  input  wire  [3:0] task_id,
  input  wire        list_select,
  input  wire  [7:0] task_priority,
  input  wire        runnable_flag,
  output logic       out_valid,
  input  wire        out_ready,
  output logic [3:0] run_task,
  output logic       task_valid,
  output logic       switched,
  output logic       no_runnable
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: one request at a time, walk step by step
  tlts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // lists, task tables, slice counter and result register
  tlts_dpath #(
    .MAX_TASKS     (MAX_TASKS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .req_type      (req_type),
    .task_id       (task_id),
    .list_select   (list_select),
    .task_priority (task_priority),
    .runnable_flag (runnable_flag),
    .run_task      (run_task),
    .task_valid    (task_valid),
    .switched      (switched),
    .no_runnable   (no_runnable)
  );

endmodule
`default_nettype wire
